### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned CELL_W     = 16;

  localparam logic REG_DEFAULT_ATTR = 1'b0;
  localparam logic REG_ERROR_ATTR   = 1'b1;

  localparam logic [7:0] RESET_DEFAULT_ATTR = 8'd15;
  localparam logic [7:0] RESET_ERROR_ATTR   = 8'd244;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_ERROR   = 8'd69;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } tcw_kind_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_SCROLL_COPY,
    S_SCROLL_FILL,
    S_CLEAR
  } tcw_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       at_cursor;
    logic [7:0] column;
    logic [7:0] line;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_line;
    logic       bad_position;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
  } tcw_out_t;

  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] error_attr;
  } tcw_cfg_t;

endpackage

### rtl/core/tcw_ram.sv
// Generic single write port, single read port RAM with registered read.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tcw_cfg.sv
// APB register bank holding the default and error attributes.
module tcw_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tcw_pkg::tcw_cfg_t                cfg_o
);

  logic [7:0] default_attr_q, default_attr_d;
  logic [7:0] error_attr_q, error_attr_d;
  logic       wr_en;

  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    default_attr_d = default_attr_q;
    error_attr_d   = error_attr_q;
    if (wr_en) begin
      unique case (paddr[2])
        tcw_pkg::REG_DEFAULT_ATTR: default_attr_d = pwdata[7:0];
        tcw_pkg::REG_ERROR_ATTR:   error_attr_d   = pwdata[7:0];
        default:                   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tcw_pkg::REG_DEFAULT_ATTR: prdata = {24'd0, default_attr_q};
      tcw_pkg::REG_ERROR_ATTR:   prdata = {24'd0, error_attr_q};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= tcw_pkg::RESET_DEFAULT_ATTR;
      error_attr_q   <= tcw_pkg::RESET_ERROR_ATTR;
    end else begin
      default_attr_q <= default_attr_d;
      error_attr_q   <= error_attr_d;
    end
  end

  assign cfg_o.default_attr = default_attr_q;
  assign cfg_o.error_attr   = error_attr_q;

endmodule

### rtl/core/tcw_ctrl.sv
// Sequencer: cursor, item decode and copy, fill and clear sweeps over the screen memory.
module tcw_ctrl #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned CELLS  = COLUMNS * ROWS,
  localparam int unsigned ADDR_W = $clog2(CELLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::tcw_cfg_t           cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcw_pkg::tcw_out_t           out_data_o,
  output logic                        mem_we_o,
  output logic [ADDR_W-1:0]           mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]  mem_wdata_o,
  output logic                        mem_re_o,
  output logic [ADDR_W-1:0]           mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata_i
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam logic [8:0] COL_LIM = 9'(COLUMNS);
  localparam logic [8:0] ROW_LIM = 9'(ROWS);
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  tcw_pkg::tcw_state_e state_q, state_d;
  tcw_pkg::tcw_in_t    item_q;
  tcw_pkg::tcw_out_t   out_q, out_d, res;
  logic                out_valid_q, out_valid_d;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [ROW_W-1:0]    cur_row_q, cur_row_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   wa_q, wa_d;
  logic                pend_q, pend_d;

  logic                go, outside, cnt_last, row_adv, scroll_now, pub;
  logic [COL_W-1:0]    tgt_col, new_col;
  logic [ROW_W-1:0]    tgt_row, new_row;
  logic [ADDR_W-1:0]   addr;
  logic [7:0]          attr_eff;
  tcw_pkg::tcw_kind_e  kind;

  // shared decode of the latched item
  always_comb begin
    kind     = tcw_pkg::tcw_kind_e'(item_q.kind);
    go       = !out_valid_q || out_ready_i;
    cnt_last = (cnt_q == LAST_CELL);
    outside  = !item_q.at_cursor &&
               (({1'b0, item_q.column} >= COL_LIM) || ({1'b0, item_q.line} >= ROW_LIM));
    tgt_col  = item_q.at_cursor ? cur_col_q : item_q.column[COL_W-1:0];
    tgt_row  = item_q.at_cursor ? cur_row_q : item_q.line[ROW_W-1:0];
    addr     = ADDR_W'(tgt_row) * ROW_STRIDE + ADDR_W'(tgt_col);
    attr_eff = (item_q.attribute == 8'd0) ? cfg_i.default_attr : item_q.attribute;
    row_adv  = (item_q.char_code == tcw_pkg::CHAR_NEWLINE) || (tgt_col == LAST_COL);
    new_col  = row_adv ? '0 : COL_W'(tgt_col + COL_W'(1));
    // past the last cell, or on a newline in the bottom row, the screen scrolls and the cursor stays on the bottom row
    scroll_now = row_adv && (tgt_row == LAST_ROW);
    new_row  = (row_adv && !scroll_now) ? ROW_W'(tgt_row + ROW_W'(1)) : tgt_row;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::S_INIT: begin
        if (cnt_last) state_d = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        unique case (kind)
          tcw_pkg::KIND_PRINT: begin
            if (!outside && scroll_now) state_d = tcw_pkg::S_SCROLL_COPY;
            else if (go)                state_d = tcw_pkg::S_IDLE;
          end
          tcw_pkg::KIND_CLEAR: state_d = tcw_pkg::S_CLEAR;
          tcw_pkg::KIND_READ: begin
            if (!outside) state_d = tcw_pkg::S_READ_WAIT;
            else if (go)  state_d = tcw_pkg::S_IDLE;
          end
          tcw_pkg::KIND_NOP: begin
            if (go) state_d = tcw_pkg::S_IDLE;
          end
          default: ;
        endcase
      end
      tcw_pkg::S_READ_WAIT: begin
        if (go) state_d = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_SCROLL_COPY: begin
        if (cnt_last) state_d = tcw_pkg::S_SCROLL_FILL;
      end
      tcw_pkg::S_SCROLL_FILL: begin
        if (!pend_q && cnt_last && go) state_d = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_CLEAR: begin
        if (cnt_last && go) state_d = tcw_pkg::S_IDLE;
      end
      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  // memory accesses, cursor, counters and result
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    cnt_d       = cnt_q;
    wa_d        = wa_q;
    pend_d      = pend_q;
    pub         = 1'b0;
    res         = '0;

    unique case (state_q)
      tcw_pkg::S_INIT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {tcw_pkg::RESET_DEFAULT_ATTR, tcw_pkg::CHAR_SPACE};
        cnt_d       = cnt_last ? '0 : ADDR_W'(cnt_q + ADDR_W'(1));
      end
      tcw_pkg::S_IDLE: ;
      tcw_pkg::S_EXEC: begin
        unique case (kind)
          tcw_pkg::KIND_PRINT: begin
            if (outside) begin
              mem_we_o         = 1'b1;
              mem_waddr_o      = LAST_CELL;
              mem_wdata_o      = {cfg_i.error_attr, tcw_pkg::CHAR_ERROR};
              res.bad_position = 1'b1;
              pub              = go;
            end else begin
              mem_we_o    = (item_q.char_code != tcw_pkg::CHAR_NEWLINE);
              mem_waddr_o = addr;
              mem_wdata_o = {attr_eff, item_q.char_code};
              if (scroll_now) begin
                cur_col_d = new_col;
                cur_row_d = new_row;
                cnt_d     = ROW_STRIDE;
                pend_d    = 1'b0;
              end else if (go) begin
                cur_col_d = new_col;
                cur_row_d = new_row;
                pub       = 1'b1;
              end
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            cnt_d = '0;
          end
          tcw_pkg::KIND_READ: begin
            if (outside) begin
              res.bad_position = 1'b1;
              pub              = go;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = addr;
            end
          end
          tcw_pkg::KIND_NOP: begin
            pub = go;
          end
          default: ;
        endcase
      end
      tcw_pkg::S_READ_WAIT: begin
        res.cell_char      = mem_rdata_i[7:0];
        res.cell_attribute = mem_rdata_i[15:8];
        pub                = go;
      end
      tcw_pkg::S_SCROLL_COPY: begin
        // read one row ahead, write back the cell read last cycle
        mem_re_o    = 1'b1;
        mem_raddr_o = cnt_q;
        mem_we_o    = pend_q;
        mem_waddr_o = wa_q;
        mem_wdata_o = mem_rdata_i;
        pend_d      = 1'b1;
        wa_d        = ADDR_W'(cnt_q - ROW_STRIDE);
        cnt_d       = cnt_last ? BOTTOM_ROW : ADDR_W'(cnt_q + ADDR_W'(1));
      end
      tcw_pkg::S_SCROLL_FILL: begin
        mem_we_o = 1'b1;
        if (pend_q) begin
          mem_waddr_o = wa_q;
          mem_wdata_o = mem_rdata_i;
          pend_d      = 1'b0;
        end else begin
          mem_wdata_o = {tcw_pkg::CHAR_NUL, tcw_pkg::CHAR_NUL};
          if (!cnt_last) begin
            cnt_d = ADDR_W'(cnt_q + ADDR_W'(1));
          end else if (go) begin
            res.scrolled = 1'b1;
            pub          = 1'b1;
          end
        end
      end
      tcw_pkg::S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {cfg_i.default_attr, tcw_pkg::CHAR_SPACE};
        if (!cnt_last) begin
          cnt_d = ADDR_W'(cnt_q + ADDR_W'(1));
        end else if (go) begin
          cur_col_d = '0;
          cur_row_d = '0;
          pub       = 1'b1;
        end
      end
      default: ;
    endcase

    res.cursor_column = 7'(cur_col_d);
    res.cursor_line   = 5'(cur_row_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pub) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_INIT;
      out_valid_q <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cnt_q       <= '0;
      wa_q        <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      cnt_q       <= cnt_d;
      wa_q        <= wa_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == tcw_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/text_console_writer.sv
// Print items that do not scroll, no-op and off-screen items go from execute straight back to idle.
// An on-screen read issues the screen memory read in execute and returns the cell in read-wait.
// A print that scrolls copies every row up by one and fills the bottom row, and a clear rewrites
// every cell, one memory write a cycle; a stalled result register holds any item in its last state.
// The result register loads at the edge that ends the item's last cycle.
// After reset a clearing pass writes a space to every cell of the screen; no item is taken meanwhile.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tcw_pkg::tcw_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tcw_pkg::tcw_out_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  tcw_pkg::tcw_cfg_t          cfg;
  logic                       mem_we, mem_re;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

  tcw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed rows, then random items.
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int unsigned COLS            = 80;
  localparam int unsigned ROWS            = 25;
  localparam int unsigned CELLS           = COLS * ROWS;
  localparam int unsigned PHASES          = 4;
  localparam int unsigned ITEMS_PER_PHASE = 425;
  localparam int unsigned QUIET_LIMIT     = 10000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_AFTER      = 250;

  typedef struct {
    tcw_in_t  item;
    bit       typed;
    tcw_out_t res;
  } dir_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  tcw_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  tcw_out_t              out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Predictor state: screen contents, cursor and the two attribute registers
  logic [15:0] screen_mem [CELLS];
  int unsigned cursor_pos;
  logic [7:0]  def_attr;
  logic [7:0]  err_attr;

  tcw_out_t    due_results [$];
  dir_row_t    dir_rows [$];
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned text_run_left = 0;

  text_console_writer #(.COLUMNS(COLS), .ROWS(ROWS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void console_reset();
    def_attr   = RESET_DEFAULT_ATTR;
    err_attr   = RESET_ERROR_ATTR;
    cursor_pos = 0;
    foreach (screen_mem[k]) screen_mem[k] = {def_attr, CHAR_SPACE};
  endfunction

  // Applies one item to the screen copy and returns the result it should produce
  function automatic tcw_out_t console_apply(tcw_in_t it);
    tcw_out_t    r;
    int unsigned pos;
    logic        outside;
    logic [7:0]  at;
    r       = '0;
    pos     = 0;
    outside = !it.at_cursor && (it.column >= COLS || it.line >= ROWS);
    if (!outside) pos = it.at_cursor ? cursor_pos : it.line * COLS + it.column;
    case (tcw_kind_e'(it.kind))
      KIND_PRINT: begin
        if (outside) begin
          screen_mem[CELLS-1] = {err_attr, CHAR_ERROR};
          r.bad_position      = 1'b1;
        end else begin
          at = (it.attribute == 8'h00) ? def_attr : it.attribute;
          if (it.char_code == CHAR_NEWLINE) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            screen_mem[pos] = {at, it.char_code};
            pos++;
          end
          if (pos >= CELLS) begin
            for (int unsigned k = 0; k < CELLS - COLS; k++) screen_mem[k] = screen_mem[k+COLS];
            for (int unsigned k = CELLS - COLS; k < CELLS; k++) screen_mem[k] = '0;
            pos        -= COLS;
            r.scrolled  = 1'b1;
          end
          cursor_pos = pos;
        end
      end
      KIND_CLEAR: begin
        foreach (screen_mem[k]) screen_mem[k] = {def_attr, CHAR_SPACE};
        cursor_pos = 0;
      end
      KIND_READ: begin
        if (outside) begin
          r.bad_position = 1'b1;
        end else begin
          r.cell_char      = screen_mem[pos][7:0];
          r.cell_attribute = screen_mem[pos][15:8];
        end
      end
      default: ;
    endcase
    r.cursor_column = 7'(cursor_pos % COLS);
    r.cursor_line   = 5'(cursor_pos / COLS);
    return r;
  endfunction

  function automatic tcw_in_t mk_item(tcw_kind_e kind, logic [7:0] ch, logic [7:0] at,
                                      logic cur, logic [7:0] col, logic [7:0] ln);
    tcw_in_t it;
    it.kind      = kind;
    it.char_code = ch;
    it.attribute = at;
    it.at_cursor = cur;
    it.column    = col;
    it.line      = ln;
    return it;
  endfunction

  function automatic tcw_out_t mk_res(int unsigned col, int unsigned ln, logic bad,
                                      logic scr, logic [7:0] ch, logic [7:0] at);
    tcw_out_t r;
    r.cursor_column  = 7'(col);
    r.cursor_line    = 5'(ln);
    r.bad_position   = bad;
    r.scrolled       = scr;
    r.cell_char      = ch;
    r.cell_attribute = at;
    return r;
  endfunction

  function automatic void add_row(tcw_in_t it, bit typed, tcw_out_t res);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // Mostly runs of printable text at the cursor, the rest scattered items and noise
  function automatic tcw_in_t random_item();
    tcw_in_t     it;
    int unsigned pick;
    it.char_code = 8'($urandom);
    it.attribute = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
    it.at_cursor = ($urandom_range(0, 4) == 0);
    it.column    = 8'($urandom_range(0, COLS - 1));
    it.line      = 8'($urandom_range(0, ROWS - 1));
    if (text_run_left > 0) begin
      text_run_left--;
      it.kind      = KIND_PRINT;
      it.at_cursor = 1'b1;
      it.column    = 8'($urandom);
      it.line      = 8'($urandom);
      it.char_code = ($urandom_range(0, 19) == 0) ? CHAR_NEWLINE : 8'($urandom_range(32, 126));
      return it;
    end
    pick = $urandom_range(0, 999);
    if (pick < 15) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 45) begin
      it.kind = KIND_NOP;
    end else if (pick < 245) begin
      it.kind = KIND_READ;
    end else begin
      it.kind = KIND_PRINT;
      if (pick < 265) text_run_left = $urandom_range(5, 120);
      if ($urandom_range(0, 19) == 0) it.char_code = CHAR_NEWLINE;
    end
    case ($urandom_range(0, 15))
      0: it.column = 8'($urandom_range(COLS, 255));
      1: it.line   = 8'($urandom_range(ROWS, 255));
      2: begin
        it.column = 8'($urandom_range(COLS, 255));
        it.line   = 8'($urandom_range(ROWS, 255));
      end
      3: begin
        it.column = 8'(COLS - 1);
        it.line   = 8'(ROWS - 1);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays high across a burst
  task automatic offer_item(tcw_in_t it, bit typed, tcw_out_t res);
    tcw_out_t r;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    r = console_apply(it);
    due_results.push_back(typed ? res : r);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_access(logic idx, logic wr, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      if (idx == REG_DEFAULT_ATTR) def_attr = val[7:0];
      else err_attr = val[7:0];
    end else if (prdata !== val) begin
      fail_count++;
      $display("%0t: register %0d read: expected %08h, got %08h", $time, idx, val, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else if (out_data_o !== due_results[0]) begin
        fail_count++;
        $display("%0t: mismatch: expected %p, got %p", $time, due_results[0], out_data_o);
        void'(due_results.pop_front());
      end else begin
        void'(due_results.pop_front());
      end
    end
  end

  // Receiver: segments of free flow, random stalls and near-blocking, one long hold-off
  initial begin : receiver
    int unsigned seg_left;
    int unsigned seg_mode;
    bit          held;
    seg_left = 0;
    seg_mode = 0;
    held     = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held        = 1'b1;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 40);
        seg_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (seg_mode)
        0, 1:    out_ready_i = 1'b1;
        2:       out_ready_i = 1'($urandom_range(0, 1));
        default: out_ready_i = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] new_def;
    logic [7:0] new_err;
    console_reset();

    // Reset contents, off-screen reads, scroll by newline and by the last cell
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
            mk_res(0, 0, 1'b0, 1'b0, CHAR_SPACE, RESET_DEFAULT_ATTR));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24), 1'b1,
            mk_res(0, 0, 1'b0, 1'b0, CHAR_SPACE, RESET_DEFAULT_ATTR));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd80, 8'd0), 1'b1,
            mk_res(0, 0, 1'b1, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd25), 1'b1,
            mk_res(0, 0, 1'b1, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF), 1'b1,
            mk_res(0, 0, 1'b1, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF), 1'b1,
            mk_res(0, 0, 1'b0, 1'b0, CHAR_SPACE, RESET_DEFAULT_ATTR));
    add_row(mk_item(KIND_PRINT, 8'h41, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
            mk_res(1, 0, 1'b0, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
            mk_res(1, 0, 1'b0, 1'b0, 8'h41, RESET_DEFAULT_ATTR));
    add_row(mk_item(KIND_PRINT, 8'hFF, 8'hFF, 1'b0, 8'd79, 8'd23), 1'b1,
            mk_res(0, 24, 1'b0, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_PRINT, CHAR_NEWLINE, 8'h07, 1'b1, 8'd0, 8'd0), 1'b1,
            mk_res(0, 24, 1'b0, 1'b1, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd22), 1'b1,
            mk_res(0, 24, 1'b0, 1'b0, 8'hFF, 8'hFF));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd5, 8'd24), 1'b1,
            mk_res(0, 24, 1'b0, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
    add_row(mk_item(KIND_PRINT, 8'h78, 8'h00, 1'b0, 8'd200, 8'd3), 1'b1,
            mk_res(0, 24, 1'b1, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24), 1'b1,
            mk_res(0, 24, 1'b0, 1'b0, CHAR_ERROR, RESET_ERROR_ATTR));
    add_row(mk_item(KIND_PRINT, 8'h00, 8'h80, 1'b1, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(mk_item(KIND_PRINT, 8'h7E, 8'h01, 1'b0, 8'd79, 8'd24), 1'b0, '0);
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd23), 1'b0, '0);
    add_row(mk_item(KIND_NOP, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(mk_item(KIND_PRINT, CHAR_NEWLINE, 8'h55, 1'b0, 8'd10, 8'd3), 1'b0, '0);
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd10, 8'd3), 1'b0, '0);
    add_row(mk_item(KIND_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
            mk_res(0, 0, 1'b0, 1'b0, CHAR_NUL, 8'h00));
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd40, 8'd12), 1'b1,
            mk_res(0, 0, 1'b0, 1'b0, CHAR_SPACE, RESET_DEFAULT_ATTR));
    add_row(mk_item(KIND_PRINT, 8'hAA, 8'h00, 1'b0, 8'h2A, 8'h15), 1'b0, '0);
    add_row(mk_item(KIND_READ, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00), 1'b0, '0);

    repeat (5) @(negedge clk);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // Attribute extremes, a random pair, then back to the reset values
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin new_def = 8'h00; new_err = 8'h00; end
        1:       begin new_def = 8'hFF; new_err = 8'hFF; end
        2:       begin new_def = 8'($urandom); new_err = 8'($urandom); end
        default: begin new_def = RESET_DEFAULT_ATTR; new_err = RESET_ERROR_ATTR; end
      endcase
      settle();
      reg_access(REG_DEFAULT_ATTR, 1'b1, {24'h0, new_def});
      reg_access(REG_ERROR_ATTR, 1'b1, {24'h0, new_err});
      reg_access(REG_DEFAULT_ATTR, 1'b0, {24'h0, new_def});
      reg_access(REG_ERROR_ATTR, 1'b0, {24'h0, new_err});
      text_run_left = 0;
      repeat (ITEMS_PER_PHASE) offer_item(random_item(), 1'b0, '0);
    end

    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_cfg.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
tb/tb_text_console_writer.sv
